### rtl/bicubic_bezier_patch_eval_assert.svh
// Assertion macros for the Bezier patch evaluator.
// Expects signals clk and rst_n in the scope that uses them.
`ifndef BICUBIC_BEZIER_PATCH_EVAL_ASSERT_SVH
`define BICUBIC_BEZIER_PATCH_EVAL_ASSERT_SVH

// same-cycle implication
`define BBPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBPE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bbpe_pkg.sv
// Shared types and constants for the bicubic Bezier patch evaluator.
// No dependencies.
package bbpe_pkg;

    localparam int GRID_SIZE_DEFAULT = 64;
    localparam int ONE_Q15           = 32768;
    localparam int NUM_AXES          = 3;
    localparam int NUM_ORDER         = 4;
    localparam int NUM_POINTS        = 16;
    localparam int GRID_ENTRIES      = 64;
    localparam int WLO_W             = 23;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } func_t;

    typedef logic signed [15:0] coord_t;
    typedef logic [15:0]        param_t;
    typedef logic [31:0]        sq_t;
    typedef logic [45:0]        weight_t;
    typedef logic [11:0]        vidx_t;
    typedef logic signed [18:0] rowpt_t;
    typedef logic signed [41:0] rsum_t;
    typedef logic signed [44:0] csum_t;

    // after grid lookup and squares
    typedef struct packed {
        logic   valid;
        func_t  func;
        logic [3:0] pidx;
        coord_t x;
        coord_t y;
        coord_t z;
        param_t u;
        param_t v;
        param_t ub;
        param_t vb;
        sq_t    uu;
        sq_t    ubb;
        sq_t    vv;
        sq_t    vbb;
        vidx_t  vidx;
    } sq_item_t;

    // after Bernstein weights
    typedef struct packed {
        logic   valid;
        func_t  func;
        logic [3:0] pidx;
        coord_t x;
        coord_t y;
        coord_t z;
        param_t u;
        param_t v;
        vidx_t  vidx;
        weight_t [NUM_ORDER-1:0] wu;
        weight_t [NUM_ORDER-1:0] wv;
    } wt_item_t;

    // row partial sums, weight split in high and low halves
    typedef struct packed {
        logic   valid;
        param_t u;
        param_t v;
        vidx_t  vidx;
        weight_t [NUM_ORDER-1:0] wv;
        rsum_t [NUM_AXES-1:0][NUM_ORDER-1:0] lo;
        rsum_t [NUM_AXES-1:0][NUM_ORDER-1:0] hi;
    } rp_item_t;

    // rounded row points
    typedef struct packed {
        logic   valid;
        param_t u;
        param_t v;
        vidx_t  vidx;
        weight_t [NUM_ORDER-1:0] wv;
        rowpt_t [NUM_AXES-1:0][NUM_ORDER-1:0] r;
    } row_item_t;

    // column partial sums
    typedef struct packed {
        logic   valid;
        param_t u;
        param_t v;
        vidx_t  vidx;
        csum_t [NUM_AXES-1:0] lo;
        csum_t [NUM_AXES-1:0] hi;
    } cp_item_t;

endpackage

### rtl/bbpe_weight.sv
// Grid parameter lookup and cubic Bernstein weights, two pipeline stages.
// Depends on bbpe_pkg.
module bbpe_weight #(
    parameter int GRID_SIZE = bbpe_pkg::GRID_SIZE_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  bbpe_pkg::func_t     func,
    input  logic [3:0]          point_index,
    input  bbpe_pkg::coord_t    ctrl_x,
    input  bbpe_pkg::coord_t    ctrl_y,
    input  bbpe_pkg::coord_t    ctrl_z,
    input  logic [5:0]          grid_i,
    input  logic [5:0]          grid_j,
    output bbpe_pkg::wt_item_t  item
);

    localparam int unsigned DEN = GRID_SIZE - 1;

    bbpe_pkg::param_t u_tab [bbpe_pkg::GRID_ENTRIES];

    for (genvar k = 0; k < bbpe_pkg::GRID_ENTRIES; k++)
    begin : g_tab
        localparam int unsigned KC = (k > DEN) ? DEN : k;
        localparam int unsigned UQ = (KC * 65536 + DEN) / (2 * DEN);
        assign u_tab[k] = 16'(UQ);
    end

    bbpe_pkg::param_t   u_lk, v_lk, ub, vb;
    bbpe_pkg::sq_item_t sq_reg, sq_next;
    bbpe_pkg::wt_item_t wt_reg, wt_next;

    assign u_lk = u_tab[grid_i];
    assign v_lk = u_tab[grid_j];
    assign ub   = 16'(bbpe_pkg::ONE_Q15) - u_lk;
    assign vb   = 16'(bbpe_pkg::ONE_Q15) - v_lk;

    always_comb
    begin
        sq_next.valid = in_valid;
        sq_next.func  = func;
        sq_next.pidx  = point_index;
        sq_next.x     = ctrl_x;
        sq_next.y     = ctrl_y;
        sq_next.z     = ctrl_z;
        sq_next.u     = u_lk;
        sq_next.v     = v_lk;
        sq_next.ub    = ub;
        sq_next.vb    = vb;
        sq_next.uu    = 32'(u_lk) * 32'(u_lk);
        sq_next.ubb   = 32'(ub) * 32'(ub);
        sq_next.vv    = 32'(v_lk) * 32'(v_lk);
        sq_next.vbb   = 32'(vb) * 32'(vb);
        // vertex number wraps to 12 bits, unclamped indices
        sq_next.vidx  = 12'(24'(grid_i) * 24'(GRID_SIZE)) + 12'(grid_j);
    end

    always_comb
    begin
        wt_next.valid = sq_reg.valid;
        wt_next.func  = sq_reg.func;
        wt_next.pidx  = sq_reg.pidx;
        wt_next.x     = sq_reg.x;
        wt_next.y     = sq_reg.y;
        wt_next.z     = sq_reg.z;
        wt_next.u     = sq_reg.u;
        wt_next.v     = sq_reg.v;
        wt_next.vidx  = sq_reg.vidx;
        wt_next.wu[0] = 46'(sq_reg.ubb) * 46'(sq_reg.ub);
        wt_next.wu[1] = 46'(3) * (46'(sq_reg.ubb) * 46'(sq_reg.u));
        wt_next.wu[2] = 46'(3) * (46'(sq_reg.uu) * 46'(sq_reg.ub));
        wt_next.wu[3] = 46'(sq_reg.uu) * 46'(sq_reg.u);
        wt_next.wv[0] = 46'(sq_reg.vbb) * 46'(sq_reg.vb);
        wt_next.wv[1] = 46'(3) * (46'(sq_reg.vbb) * 46'(sq_reg.v));
        wt_next.wv[2] = 46'(3) * (46'(sq_reg.vv) * 46'(sq_reg.vb));
        wt_next.wv[3] = 46'(sq_reg.vv) * 46'(sq_reg.v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg <= '0;
            wt_reg <= '0;
        end
        else if (adv)
        begin
            sq_reg <= sq_next;
            wt_reg <= wt_next;
        end
    end

    assign item = wt_reg;

endmodule

### rtl/bbpe_rows.sv
// Control point store and per-row Bernstein evaluation along u, two stages.
// Depends on bbpe_pkg.
module bbpe_rows (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  bbpe_pkg::wt_item_t  in_item,
    output bbpe_pkg::row_item_t item
);

    localparam int NA = bbpe_pkg::NUM_AXES;
    localparam int NO = bbpe_pkg::NUM_ORDER;
    localparam int WL = bbpe_pkg::WLO_W;

    bbpe_pkg::coord_t [NA-1:0] cp_reg  [bbpe_pkg::NUM_POINTS];
    bbpe_pkg::coord_t [NA-1:0] cp_next [bbpe_pkg::NUM_POINTS];
    bbpe_pkg::rp_item_t  rp_reg, rp_next;
    bbpe_pkg::row_item_t row_reg, row_next;

    logic wr_en;

    // loads write here, in order with the evaluations that read the store
    assign wr_en = adv && in_item.valid && (in_item.func == bbpe_pkg::FUNC_LOAD);

    always_comb
    begin
        cp_next = cp_reg;
        if (wr_en)
        begin
            cp_next[in_item.pidx][0] = in_item.x;
            cp_next[in_item.pidx][1] = in_item.y;
            cp_next[in_item.pidx][2] = in_item.z;
        end
    end

    always_comb
    begin
        logic signed [39:0] p_lo;
        logic signed [39:0] p_hi;
        bbpe_pkg::rsum_t    s_lo;
        bbpe_pkg::rsum_t    s_hi;
        rp_next.valid = in_item.valid && (in_item.func == bbpe_pkg::FUNC_EVAL);
        rp_next.u     = in_item.u;
        rp_next.v     = in_item.v;
        rp_next.vidx  = in_item.vidx;
        rp_next.wv    = in_item.wv;
        for (int a = 0; a < NA; a++)
        begin
            for (int r = 0; r < NO; r++)
            begin
                s_lo = '0;
                s_hi = '0;
                for (int c = 0; c < NO; c++)
                begin
                    p_lo = cp_reg[r*NO + c][a] * $signed({1'b0, in_item.wu[c][WL-1:0]});
                    p_hi = cp_reg[r*NO + c][a] * $signed({1'b0, in_item.wu[c][45:WL]});
                    s_lo = s_lo + 42'(p_lo);
                    s_hi = s_hi + 42'(p_hi);
                end
                rp_next.lo[a][r] = s_lo;
                rp_next.hi[a][r] = s_hi;
            end
        end
    end

    always_comb
    begin
        logic signed [63:0] rsum;
        logic signed [63:0] rsh;
        row_next.valid = rp_reg.valid;
        row_next.u     = rp_reg.u;
        row_next.v     = rp_reg.v;
        row_next.vidx  = rp_reg.vidx;
        row_next.wv    = rp_reg.wv;
        for (int a = 0; a < NA; a++)
        begin
            for (int r = 0; r < NO; r++)
            begin
                rsum = (64'(rp_reg.hi[a][r]) <<< WL) + 64'(rp_reg.lo[a][r]);
                // round to Q4.14, ties up
                rsh  = (rsum + (64'sd1 <<< 42)) >>> 43;
                row_next.r[a][r] = 19'(rsh);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < bbpe_pkg::NUM_POINTS; k++)
            begin
                cp_reg[k] <= '0;
            end
            rp_reg  <= '0;
            row_reg <= '0;
        end
        else
        begin
            cp_reg <= cp_next;
            if (adv)
            begin
                rp_reg  <= rp_next;
                row_reg <= row_next;
            end
        end
    end

    assign item = row_reg;

endmodule

### rtl/bbpe_blend.sv
// Combines the four row points along v, rounds and saturates, two stages.
// Depends on bbpe_pkg.
module bbpe_blend (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  bbpe_pkg::row_item_t in_item,
    output logic                out_valid,
    output bbpe_pkg::coord_t    pos_x,
    output bbpe_pkg::coord_t    pos_y,
    output bbpe_pkg::coord_t    pos_z,
    output bbpe_pkg::param_t    tex_u,
    output bbpe_pkg::param_t    tex_v,
    output bbpe_pkg::vidx_t     vertex_index
);

    localparam int NA = bbpe_pkg::NUM_AXES;
    localparam int NO = bbpe_pkg::NUM_ORDER;
    localparam int WL = bbpe_pkg::WLO_W;

    bbpe_pkg::cp_item_t cs_reg, cs_next;
    logic               ov_reg, ov_next;
    bbpe_pkg::coord_t [NA-1:0] pos_reg, pos_next;
    bbpe_pkg::param_t   u_reg, u_next, v_reg, v_next;
    bbpe_pkg::vidx_t    vi_reg, vi_next;

    always_comb
    begin
        logic signed [42:0] p_lo;
        logic signed [42:0] p_hi;
        bbpe_pkg::csum_t    s_lo;
        bbpe_pkg::csum_t    s_hi;
        cs_next.valid = in_item.valid;
        cs_next.u     = in_item.u;
        cs_next.v     = in_item.v;
        cs_next.vidx  = in_item.vidx;
        for (int a = 0; a < NA; a++)
        begin
            s_lo = '0;
            s_hi = '0;
            for (int r = 0; r < NO; r++)
            begin
                p_lo = in_item.r[a][r] * $signed({1'b0, in_item.wv[r][WL-1:0]});
                p_hi = in_item.r[a][r] * $signed({1'b0, in_item.wv[r][45:WL]});
                s_lo = s_lo + 45'(p_lo);
                s_hi = s_hi + 45'(p_hi);
            end
            cs_next.lo[a] = s_lo;
            cs_next.hi[a] = s_hi;
        end
    end

    always_comb
    begin
        logic signed [67:0] acc;
        logic signed [67:0] ash;
        ov_next = cs_reg.valid;
        u_next  = cs_reg.u;
        v_next  = cs_reg.v;
        vi_next = cs_reg.vidx;
        for (int a = 0; a < NA; a++)
        begin
            acc = (68'(cs_reg.hi[a]) <<< WL) + 68'(cs_reg.lo[a]);
            ash = (acc + (68'sd1 <<< 46)) >>> 47;
            // clamp to the Q4.12 range
            if (ash > 68'sd32767)
            begin
                pos_next[a] = 16'sh7FFF;
            end
            else if (ash < -68'sd32768)
            begin
                pos_next[a] = 16'sh8000;
            end
            else
            begin
                pos_next[a] = 16'(ash);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg  <= '0;
            ov_reg  <= 1'b0;
            pos_reg <= '0;
            u_reg   <= '0;
            v_reg   <= '0;
            vi_reg  <= '0;
        end
        else if (adv)
        begin
            cs_reg  <= cs_next;
            ov_reg  <= ov_next;
            pos_reg <= pos_next;
            u_reg   <= u_next;
            v_reg   <= v_next;
            vi_reg  <= vi_next;
        end
    end

    assign out_valid    = ov_reg;
    assign pos_x        = pos_reg[0];
    assign pos_y        = pos_reg[1];
    assign pos_z        = pos_reg[2];
    assign tex_u        = u_reg;
    assign tex_v        = v_reg;
    assign vertex_index = vi_reg;

endmodule

### rtl/bicubic_bezier_patch_eval.sv
// Top level of the bicubic Bezier patch evaluator.
// Depends on bbpe_pkg, bbpe_weight, bbpe_rows, bbpe_blend and the assert header.
//
//  channel | handshake            | word
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | func point_index ctrl_x/y/z grid_i grid_j
//  out     | out_valid / out_ready| pos_x/y/z tex_u tex_v vertex_index
//
// Six register stages (sq, wt, rp, row, cs, output): one word enters per clock
// unless the output stalls; loads give no vertex.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stalled vertex holds every stage in place.
// Reset clears the 16 control points to zero and all stage valid bits.
module bicubic_bezier_patch_eval #(
    parameter int GRID_SIZE = bbpe_pkg::GRID_SIZE_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [3:0]          point_index,
    input  logic signed [15:0]  ctrl_x,
    input  logic signed [15:0]  ctrl_y,
    input  logic signed [15:0]  ctrl_z,
    input  logic [5:0]          grid_i,
    input  logic [5:0]          grid_j,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  pos_x,
    output logic signed [15:0]  pos_y,
    output logic signed [15:0]  pos_z,
    output logic [15:0]         tex_u,
    output logic [15:0]         tex_v,
    output logic [11:0]         vertex_index
);

    logic                adv;
    bbpe_pkg::wt_item_t  wt_item;
    bbpe_pkg::row_item_t row_item;
    logic                tex_ok;
    logic                out_stall;
    logic [91:0]         out_word;

    // advance when the output slot is free or drains this cycle
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    bbpe_weight #(
        .GRID_SIZE (GRID_SIZE)
    ) u_weight (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (in_valid),
        .func        (bbpe_pkg::func_t'(func)),
        .point_index (point_index),
        .ctrl_x      (ctrl_x),
        .ctrl_y      (ctrl_y),
        .ctrl_z      (ctrl_z),
        .grid_i      (grid_i),
        .grid_j      (grid_j),
        .item        (wt_item)
    );

    bbpe_rows u_rows (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_item (wt_item),
        .item    (row_item)
    );

    bbpe_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_item      (row_item),
        .out_valid    (out_valid),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .vertex_index (vertex_index)
    );

    assign tex_ok    = (tex_u <= 16'h8000) && (tex_v <= 16'h8000);
    assign out_stall = out_valid && !out_ready;
    assign out_word  = {pos_x, pos_y, pos_z, tex_u, tex_v, vertex_index};

`include "bicubic_bezier_patch_eval_assert.svh"

    `BBPE_ASSERT_IMP(a_tex_range, out_valid, tex_ok, "texture coordinate above one")
    `BBPE_ASSERT_NXT(a_stall_holds, !in_ready, $stable(row_item), "row stage moved in stall")
    `BBPE_ASSERT_NXT(a_out_holds, out_stall, out_valid && $stable(out_word), "output word moved")

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for bicubic_bezier_patch_eval: loads control points, evaluates
// grid vertices and checks each one against a bit-exact fixed-point Bezier predictor.
// Depends on bbpe_pkg and the RTL of the block.
module tb_top;

    localparam int GRID = 64;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [11:0]        vidx;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic func = bbpe_pkg::FUNC_LOAD;
    logic [3:0] point_index = '0;
    logic signed [15:0] ctrl_x = '0;
    logic signed [15:0] ctrl_y = '0;
    logic signed [15:0] ctrl_z = '0;
    logic [5:0] grid_i = '0;
    logic [5:0] grid_j = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] pos_x, pos_y, pos_z;
    logic [15:0] tex_u, tex_v;
    logic [11:0] vertex_index;

    logic signed [15:0] patch_pt[bbpe_pkg::NUM_POINTS][bbpe_pkg::NUM_AXES];
    vertex_t vertex_q[$];
    int  n_err = 0;
    bit  idle_en = 1'b1;
    int  hold_reqs = 0;
    int  quiet_cycles = 0;

    bicubic_bezier_patch_eval #(.GRID_SIZE(GRID)) DUT (.*);

    always #5 clk = ~clk;

    function automatic longint grid_to_param(input logic [5:0] idx);
        longint k;
        k = (idx > GRID - 1) ? GRID - 1 : idx;
        return (k * 65536 + (GRID - 1)) / (2 * (GRID - 1));
    endfunction

    function automatic void bernstein_weights(input longint t, output longint w[4]);
        longint b;
        b = 32768 - t;
        w[0] = b * b * b;
        w[1] = 3 * b * b * t;
        w[2] = 3 * b * t * t;
        w[3] = t * t * t;
    endfunction

    // add half, then floor
    function automatic longint round_down(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic vertex_t eval_patch(input logic [5:0] i, input logic [5:0] j);
        vertex_t r;
        longint wu[4], wv[4];
        longint acc, row, res;
        logic signed [15:0] s16;
        r.u = 16'(grid_to_param(i));
        r.v = 16'(grid_to_param(j));
        bernstein_weights(r.u, wu);
        bernstein_weights(r.v, wv);
        for (int a = 0; a < bbpe_pkg::NUM_AXES; a++)
        begin
            acc = 0;
            for (int rr = 0; rr < 4; rr++)
            begin
                row = 0;
                for (int c = 0; c < 4; c++)
                    row += longint'(patch_pt[rr * 4 + c][a]) * wu[c];
                acc += round_down(row, 43) * wv[rr];
            end
            res = round_down(acc, 47);
            if (res > 32767) res = 32767;
            if (res < -32768) res = -32768;
            s16 = res[15:0];
            if (a == 0) r.px = s16;
            else if (a == 1) r.py = s16;
            else r.pz = s16;
        end
        r.vidx = 12'(i * GRID + j);
        return r;
    endfunction

    task automatic send_word(input bbpe_pkg::func_t f, input logic [3:0] pi,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [5:0] i,
                             input logic [5:0] j);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        point_index <= pi;
        ctrl_x <= x;
        ctrl_y <= y;
        ctrl_z <= z;
        grid_i <= i;
        grid_j <= j;
        do @(posedge clk); while (!in_ready);
        if (f == bbpe_pkg::FUNC_LOAD)
        begin
            patch_pt[pi][0] = x;
            patch_pt[pi][1] = y;
            patch_pt[pi][2] = z;
        end
        else
            vertex_q = {vertex_q, eval_patch(i, j)};
    endtask

    task automatic send_random(input int load_pct);
        bbpe_pkg::func_t f;
        f = ($urandom_range(0, 99) < load_pct) ? bbpe_pkg::FUNC_LOAD : bbpe_pkg::FUNC_EVAL;
        send_word(f, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  6'($urandom), 6'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge clk);
    endtask

    task automatic fill_patch(input logic [15:0] val);
        for (int k = 0; k < bbpe_pkg::NUM_POINTS; k++)
            send_word(bbpe_pkg::FUNC_LOAD, 4'(k), val, val, val, 6'($urandom), 6'($urandom));
    endtask

    task automatic test_reset_patch();
        // zero patch straight from reset, opposite corners
        send_word(bbpe_pkg::FUNC_EVAL, 4'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 6'd0, 6'd0);
        send_word(bbpe_pkg::FUNC_EVAL, 4'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 6'd63, 6'd63);
    endtask

    task automatic test_extremes();
        fill_patch(16'h7fff);
        send_word(bbpe_pkg::FUNC_EVAL, 4'd0, '0, '0, '0, 6'd31, 6'd62);
        fill_patch(16'h8000);
        send_word(bbpe_pkg::FUNC_EVAL, 4'd0, '0, '0, '0, 6'd1, 6'd63);
        // extremes striped by column on x and by slot index mod 3 on y, random z per slot
        for (int k = 0; k < bbpe_pkg::NUM_POINTS; k++)
            send_word(bbpe_pkg::FUNC_LOAD, 4'(k), (k % 2) ? 16'h7fff : 16'h8000,
                      (k % 3) ? 16'h8000 : 16'h7fff, 16'($urandom), 6'h3f, 6'h3f);
        send_word(bbpe_pkg::FUNC_EVAL, 4'hf, 16'hffff, 16'hffff, 16'hffff, 6'd0, 6'd63);
        send_word(bbpe_pkg::FUNC_EVAL, 4'h0, '0, '0, '0, 6'd32, 6'd21);
        send_word(bbpe_pkg::FUNC_EVAL, 4'h5, '0, '0, '0, 6'd63, 6'd0);
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < 1000; n++)
            send_random(25);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_reqs = hold_reqs + 1;
        for (int n = 0; n < 60; n++)
            send_random(20);
    endtask

    task automatic test_pause_drain();
        for (int n = 0; n < 20; n++)
            send_random(20);
        wait_drained();
        for (int n = 0; n < 20; n++)
            send_random(20);
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        for (int n = 0; n < 100; n++)
            send_random(15);
    endtask

    // receiver: random stall bursts plus one long hold on request
    always @(posedge clk)
    begin
        static int burst = 0;
        static int hold_left = 0;
        static int hold_seen = 0;
        logic rdy;
        rdy = 1'b1;
        if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else if (burst > 0)
        begin
            burst--;
            rdy = 1'b0;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            burst = $urandom_range(0, 17);
            rdy = 1'b0;
        end
        if (!rst_n) rdy = 1'b0;
        out_ready <= rdy;
    end

    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (vertex_q.size() == 0)
            begin
                $error("vertex with nothing expected, index %0d", vertex_index);
                n_err++;
            end
            else
            begin
                e = vertex_q.pop_front();
                if (pos_x !== e.px)
                begin
                    $error("pos_x expected %0d got %0d", e.px, pos_x); n_err++;
                end
                if (pos_y !== e.py)
                begin
                    $error("pos_y expected %0d got %0d", e.py, pos_y); n_err++;
                end
                if (pos_z !== e.pz)
                begin
                    $error("pos_z expected %0d got %0d", e.pz, pos_z); n_err++;
                end
                if (tex_u !== e.u)
                begin
                    $error("tex_u expected %0d got %0d", e.u, tex_u); n_err++;
                end
                if (tex_v !== e.v)
                begin
                    $error("tex_v expected %0d got %0d", e.v, tex_v); n_err++;
                end
                if (vertex_index !== e.vidx)
                begin
                    $error("vertex_index expected %0d got %0d", e.vidx, vertex_index);
                    n_err++;
                end
            end
        end
    end

    // count cycles where no word moves on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < bbpe_pkg::NUM_POINTS; k++)
            for (int a = 0; a < bbpe_pkg::NUM_AXES; a++)
                patch_pt[k][a] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_patch();
        test_extremes();
        test_random_mix();
        test_backpressure();
        test_pause_drain();
        test_full_rate();
        wait_drained();
        repeat (20) @(posedge clk);
        if (n_err == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
